@@ rtl/pbu_pkg.sv @@
package pbu_pkg;

  // width of every pixel channel on the streams
  localparam int FIELD_W = 13;
  localparam int CFG_W   = 2;

  typedef enum logic [CFG_W-1:0] {
    MODE_OVER = 2'd0,
    MODE_MUL  = 2'd1,
    MODE_ADD  = 2'd2,
    MODE_AVG  = 2'd3
  } blend_mode_e;

endpackage

@@ rtl/pixel_blend_unit_top.sv @@
// pipeline from input transaction to output transaction: clamp, weight, products,
// FRAC_BITS + 1 divider stages, output register
// throughput: one pixel per cycle; the restoring divider is fully pipelined, one
// quotient bit per stage, and a stall on the output side holds every stage
// reset: asynchronous active low, clears valid bits and blend_mode (alpha over)
module pixel_blend_unit_top
  import pbu_pkg::*;
#(
  parameter int FRAC_BITS = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // bg_red, bg_green, bg_blue, bg_alpha, fg_red, fg_green, fg_blue, fg_alpha
  input  logic [103:0] s_axis_tdata,
  // output stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_red, out_green, out_blue, out_alpha, 4 zero bits
  output logic [55:0]  m_axis_tdata,
  // configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int CW    = FIELD_W;
  localparam int ONE_W = FRAC_BITS + 2;
  localparam int QW    = FRAC_BITS + 1;        // quotient never exceeds 1.0
  localparam int NAW   = CW + 1;               // output alpha before saturation
  localparam int NW    = 2 * CW + 1;           // blend numerator
  localparam int DW    = NW + QW;              // divider compare width
  localparam int SAT_I = (FRAC_BITS >= CW) ? ((1 << CW) - 1) : (1 << FRAC_BITS);
  localparam logic [CW-1:0]    SAT = CW'(SAT_I);
  localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;

  // per-stage payload
  typedef struct packed {
    blend_mode_e              mode;
    logic [2:0][CW-1:0]       bc;
    logic [2:0][CW-1:0]       fc;
    logic [CW-1:0]            fa;
    logic [CW-1:0]            wt;
    logic [3:0][CW-1:0]       alt;
  } mid_t;

  typedef struct packed {
    blend_mode_e              mode;
    logic [NAW-1:0]           na;
    logic [2:0][NW-1:0]       rem;
    logic [2:0][QW-1:0]       quo;
    logic [3:0][CW-1:0]       alt;
  } div_t;

  function automatic logic [CW-1:0] sat_val(input logic [NW-1:0] v);
    return (v > NW'(SAT)) ? SAT : v[CW-1:0];
  endfunction

  function automatic logic [CW-1:0] clamp_in(input logic [CW-1:0] v);
    return (v > SAT) ? SAT : v;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration register, one word, upper address bit selects nothing valid
  // ---------------------------------------------------------------------------
  blend_mode_e mode_q;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {{(32 - CFG_W){1'b0}}, mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_OVER;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      mode_q <= blend_mode_e'(pwdata[CFG_W-1:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: all stages advance together unless the output stalls
  // ---------------------------------------------------------------------------
  logic en;
  logic out_vld_q;

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: clamp inputs to 1.0
  logic                 s1_vld_q;
  blend_mode_e          s1_mode_q;
  logic [3:0][CW-1:0]   s1_bg_q, s1_fg_q;
  logic [3:0][CW-1:0]   s1_bg_d, s1_fg_d;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      s1_bg_d[i] = clamp_in(s_axis_tdata[i*CW +: CW]);
      s1_fg_d[i] = clamp_in(s_axis_tdata[(4+i)*CW +: CW]);
    end
  end

  // stage 2: background weight, and the results of the simple modes
  logic                 s2_vld_q;
  mid_t                 s2_q, s2_d;

  always_comb begin
    logic [CW+ONE_W-1:0] wprod;
    logic [2*CW-1:0]     mprod;
    logic [CW:0]         sum;
    wprod = (CW+ONE_W)'(s1_bg_q[3]) * (CW+ONE_W)'(ONE - ONE_W'(s1_fg_q[3]));
    s2_d.mode = s1_mode_q;
    s2_d.fa   = s1_fg_q[3];
    s2_d.wt   = CW'(wprod >> FRAC_BITS);
    for (int i = 0; i < 3; i++) begin
      s2_d.bc[i] = s1_bg_q[i];
      s2_d.fc[i] = s1_fg_q[i];
    end
    for (int i = 0; i < 4; i++) begin
      mprod = (2*CW)'(s1_bg_q[i]) * (2*CW)'(s1_fg_q[i]);
      sum   = {1'b0, s1_bg_q[i]} + {1'b0, s1_fg_q[i]};
      case (s1_mode_q)
        MODE_MUL: s2_d.alt[i] = sat_val(NW'(mprod >> FRAC_BITS));
        MODE_ADD: s2_d.alt[i] = sat_val(NW'(sum));
        MODE_AVG: s2_d.alt[i] = sat_val(NW'(sum >> 1));
        default:  s2_d.alt[i] = '0;
      endcase
      // add and average keep the larger alpha
      if (i == 3 && (s1_mode_q == MODE_ADD || s1_mode_q == MODE_AVG)) begin
        s2_d.alt[i] = (s1_bg_q[3] > s1_fg_q[3]) ? s1_bg_q[3] : s1_fg_q[3];
      end
    end
  end

  // stage 3: output alpha and weighted numerators
  div_t s3_d;

  always_comb begin
    s3_d.mode = s2_q.mode;
    s3_d.na   = {1'b0, s2_q.fa} + {1'b0, s2_q.wt};
    s3_d.alt  = s2_q.alt;
    s3_d.quo  = '0;
    for (int i = 0; i < 3; i++) begin
      s3_d.rem[i] = NW'(s2_q.fc[i]) * NW'(s2_q.fa) + NW'(s2_q.bc[i]) * NW'(s2_q.wt);
    end
  end

  // divider stages: index 0 holds stage 3, stage j resolves quotient bit QW-j
  logic [QW:0] dv_vld_q;
  div_t        dv_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_mode_q <= mode_q;
      s1_bg_q   <= s1_bg_d;
      s1_fg_q   <= s1_fg_d;
      s2_q      <= s2_d;
      dv_q[0]   <= s3_d;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    localparam int B = QW - j;
    div_t step_d;

    always_comb begin
      logic [DW-1:0] trial;
      trial  = DW'(dv_q[j-1].na) << B;
      step_d = dv_q[j-1];
      for (int i = 0; i < 3; i++) begin
        if (DW'(dv_q[j-1].rem[i]) >= trial) begin
          step_d.rem[i]    = dv_q[j-1].rem[i] - NW'(trial);
          step_d.quo[i][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[j] <= step_d;
      end
    end
  end

  // output register
  logic [3:0][CW-1:0] out_q, out_d;

  always_comb begin
    if (dv_q[QW].mode == MODE_OVER) begin
      // zero output alpha gives an all-zero pixel
      if (dv_q[QW].na == '0) begin
        out_d = '0;
      end else begin
        for (int i = 0; i < 3; i++) begin
          out_d[i] = sat_val(NW'(dv_q[QW].quo[i]));
        end
        out_d[3] = sat_val(NW'(dv_q[QW].na));
      end
    end else begin
      out_d = dv_q[QW].alt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q  <= s_axis_tvalid;
      s2_vld_q  <= s1_vld_q;
      dv_vld_q  <= {dv_vld_q[QW-1:0], s2_vld_q};
      out_vld_q <= dv_vld_q[QW];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'd0, out_q};

endmodule
